// ----- rtl/salsa_pkg.sv -----
// salsa_pkg: shared types, constants and lookup functions of the salsa20 core
package salsa_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned STATE_WORDS = 16;
    localparam int unsigned WADDR_W     = 4;
    localparam int unsigned POS_W       = 7;

    localparam logic [POS_W-1:0] BLOCK_BYTES = 7'd64;
    localparam logic [4:0]       ROUNDS_RESET = 5'd20;

    // expansion constants, sigma for 256-bit keys, tau for 128-bit keys
    localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
    localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
    localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
    localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;
    localparam logic [WORD_W-1:0] TAU1   = 32'h3120646e;
    localparam logic [WORD_W-1:0] TAU2   = 32'h79622d36;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY0   = 3'd0;
    localparam logic [2:0] CFG_KEY1   = 3'd1;
    localparam logic [2:0] CFG_KEY2   = 3'd2;
    localparam logic [2:0] CFG_KEY3   = 3'd3;
    localparam logic [2:0] CFG_SHORT  = 3'd4;
    localparam logic [2:0] CFG_NONCE  = 3'd5;
    localparam logic [2:0] CFG_ROUNDS = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_QLOAD,
        ST_QWAIT,
        ST_QCALC,
        ST_QSTORE,
        ST_FF_RD,
        ST_FF_WR,
        ST_KS_RD,
        ST_KS_OUT
    } salsa_state_t;

    typedef enum logic [2:0] {
        ROT_0,
        ROT_7,
        ROT_9,
        ROT_13,
        ROT_18
    } salsa_rot_t;

    // sequencer position handed to the datapath
    typedef struct packed {
        salsa_state_t         state;
        logic [1:0]           step;
        logic [2:0]           quarter;
        logic [WADDR_W-1:0]   widx;
    } salsa_ctl_t;

    // state word touched by a quarter round; quarters 0-3 columns, 4-7 rows
    function automatic logic [WADDR_W-1:0] qr_addr(input logic [2:0] quarter,
                                                   input logic [1:0] step);
        logic [15:0] row;
        unique case (quarter)
            3'd0:    row = {4'd12, 4'd8,  4'd4,  4'd0};
            3'd1:    row = {4'd1,  4'd13, 4'd9,  4'd5};
            3'd2:    row = {4'd6,  4'd2,  4'd14, 4'd10};
            3'd3:    row = {4'd11, 4'd7,  4'd3,  4'd15};
            3'd4:    row = {4'd3,  4'd2,  4'd1,  4'd0};
            3'd5:    row = {4'd4,  4'd7,  4'd6,  4'd5};
            3'd6:    row = {4'd9,  4'd8,  4'd11, 4'd10};
            3'd7:    row = {4'd14, 4'd13, 4'd12, 4'd15};
            default: row = '0;
        endcase
        return row[{step, 2'b00} +: WADDR_W];
    endfunction

    // rotate amount of each quarter round step
    function automatic salsa_rot_t rot_of(input logic [1:0] step);
        salsa_rot_t r;
        unique case (step)
            2'd0:    r = ROT_7;
            2'd1:    r = ROT_9;
            2'd2:    r = ROT_13;
            2'd3:    r = ROT_18;
            default: r = ROT_0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/salsa_ram.sv -----
// salsa_ram: generic single write, single read ram with registered read data
module salsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/salsa_alu.sv -----
// salsa_alu: shared 32-bit adder with constant rotate for rounds and feed-forward
module salsa_alu import salsa_pkg::*; (
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    input  salsa_rot_t        rot,
    output logic [WORD_W-1:0] y
);

    logic [WORD_W-1:0] sum;

    assign sum = a + b;

    // rotate left by the selected amount
    always_comb
    begin
        unique case (rot)
            ROT_0:   y = sum;
            ROT_7:   y = {sum[24:0], sum[31:25]};
            ROT_9:   y = {sum[22:0], sum[31:23]};
            ROT_13:  y = {sum[18:0], sum[31:19]};
            ROT_18:  y = {sum[13:0], sum[31:14]};
            default: y = sum;
        endcase
    end

endmodule

// ----- rtl/salsa_ctrl.sv -----
// salsa_ctrl: sequencer stepping the shared unit through block generation
module salsa_ctrl import salsa_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       need_block,
    input  logic       out_free,
    input  logic [4:0] dr_total,
    output salsa_ctl_t ctl
);

    salsa_state_t       state_reg, state_next;
    logic [1:0]         step_reg, step_next;
    logic [2:0]         quarter_reg, quarter_next;
    logic [WADDR_W-1:0] widx_reg, widx_next;
    logic [4:0]         dr_reg, dr_next;
    logic               last_dr;

    assign last_dr = (dr_reg + 5'd1) == dr_total;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = need_block ? ST_INIT : ST_KS_OUT;
                end
            end
            ST_INIT:
            begin
                if (widx_reg == 4'd15)
                begin
                    state_next = (dr_total == 5'd0) ? ST_FF_RD : ST_QLOAD;
                end
            end
            ST_QLOAD:
            begin
                if (step_reg == 2'd3)
                begin
                    state_next = ST_QWAIT;
                end
            end
            ST_QWAIT:  state_next = ST_QCALC;
            ST_QCALC:
            begin
                if (step_reg == 2'd3)
                begin
                    state_next = ST_QSTORE;
                end
            end
            ST_QSTORE:
            begin
                if (step_reg == 2'd3)
                begin
                    state_next = (quarter_reg == 3'd7 && last_dr) ? ST_FF_RD : ST_QLOAD;
                end
            end
            ST_FF_RD:  state_next = ST_FF_WR;
            ST_FF_WR:
            begin
                state_next = (widx_reg == 4'd15) ? ST_KS_RD : ST_FF_RD;
            end
            ST_KS_RD:  state_next = ST_KS_OUT;
            ST_KS_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // step, quarter, word and double round counters
    always_comb
    begin
        step_next    = step_reg;
        quarter_next = quarter_reg;
        widx_next    = widx_reg;
        dr_next      = dr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next    = '0;
                quarter_next = '0;
                widx_next    = '0;
                dr_next      = '0;
            end
            ST_INIT:   widx_next = widx_reg + 4'd1;
            ST_QLOAD:  step_next = step_reg + 2'd1;
            ST_QWAIT:  step_next = '0;
            ST_QCALC:  step_next = step_reg + 2'd1;
            ST_QSTORE:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    quarter_next = quarter_reg + 3'd1;
                    if (quarter_reg == 3'd7)
                    begin
                        dr_next = dr_reg + 5'd1;
                    end
                end
            end
            ST_FF_WR:  widx_next = widx_reg + 4'd1;
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            quarter_reg <= '0;
            widx_reg    <= '0;
            dr_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            quarter_reg <= quarter_next;
            widx_reg    <= widx_next;
            dr_reg      <= dr_next;
        end
    end

    // outputs to the datapath
    always_comb
    begin
        ctl.state   = state_reg;
        ctl.step    = step_reg;
        ctl.quarter = quarter_reg;
        ctl.widx    = widx_reg;
    end

endmodule

// ----- rtl/salsa20_stream_cipher_core.sv -----
// salsa20_stream_cipher_core: byte-wide salsa20 keystream xor, top level
//
// Input bytes arrive on s_tvalid/s_tready/s_tdata, results leave on
// m_tvalid/m_tready/m_tdata, one result per input transaction, in order.
// Key, nonce, key mode and round count are written through cfg_we,
// cfg_addr and cfg_wdata while no transaction is in flight; any write to
// a defined index restarts the stream at block counter zero.
// A byte taken from a ready keystream block is accepted, then loaded into
// the output register from the registered state ram read once it is free.
// The first byte of each 64-byte block first runs the block function on
// the one shared adder/rotator: accept, load the 16 state words, then
// per quarter round 4 reads, 1 wait, 4 steps and 4 writes, 8 quarter rounds
// per double round, ceil(round_count / 2) double rounds, then the
// feed-forward of the 16 words and the fetch and load of the byte.
// s_tready is high only while the sequencer is idle; a held result in the
// output register does not block the next input transaction.
// If m_tready stays low, the next result waits until the register frees.
// Reset clears the configuration to zero keys and 20 rounds, the block
// counter to zero and marks the keystream block as used up.
module salsa20_stream_cipher_core import salsa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // data_in[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // data_out[7:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);

    // configuration registers
    logic [63:0]        key0_reg, key1_reg, key2_reg, key3_reg, nonce_reg;
    logic               short_reg;
    logic [4:0]         rounds_reg;

    // stream state
    logic [63:0]        counter_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [7:0]         data_reg;
    logic               m_valid_reg;
    logic [7:0]         m_data_reg;

    // quarter round working words
    logic [WORD_W-1:0]  w0_reg, w1_reg, w2_reg, w3_reg;
    logic               cap_en_reg;
    logic [1:0]         cap_idx_reg;

    salsa_ctl_t         ctl;
    logic               start, need_block, out_free, cfg_hit, block_done, deliver;
    logic [4:0]         dr_total;
    logic [WORD_W-1:0]  in_word, alu_a, alu_b, alu_y, w_sel;
    salsa_rot_t         alu_rot;
    logic               ram_we, ram_re;
    logic [WADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;
    logic [7:0]         ks_byte;

    assign s_tready   = ctl.state == ST_IDLE;
    assign start      = s_tvalid && s_tready;
    assign need_block = pos_reg >= BLOCK_BYTES;
    assign out_free   = !m_valid_reg || m_tready;
    assign deliver    = (ctl.state == ST_KS_OUT) && out_free;
    assign block_done = (ctl.state == ST_FF_WR) && (ctl.widx == 4'd15);
    assign cfg_hit    = cfg_we && (cfg_addr <= CFG_ROUNDS);
    assign dr_total   = 5'(({1'b0, rounds_reg} + 6'd1) >> 1);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    salsa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .need_block (need_block),
        .out_free   (out_free),
        .dr_total   (dr_total),
        .ctl        (ctl)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg   <= '0;
            key1_reg   <= '0;
            key2_reg   <= '0;
            key3_reg   <= '0;
            short_reg  <= 1'b0;
            nonce_reg  <= '0;
            rounds_reg <= ROUNDS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_KEY0:   key0_reg   <= cfg_wdata;
                CFG_KEY1:   key1_reg   <= cfg_wdata;
                CFG_KEY2:   key2_reg   <= cfg_wdata;
                CFG_KEY3:   key3_reg   <= cfg_wdata;
                CFG_SHORT:  short_reg  <= cfg_wdata[0];
                CFG_NONCE:  nonce_reg  <= cfg_wdata;
                CFG_ROUNDS: rounds_reg <= cfg_wdata[4:0];
                default:    rounds_reg <= rounds_reg;
            endcase
        end
    end

    // block function input word for the current word index
    always_comb
    begin
        unique case (ctl.widx)
            4'd0:    in_word = SIGMA0;
            4'd1:    in_word = key0_reg[31:0];
            4'd2:    in_word = key0_reg[63:32];
            4'd3:    in_word = key1_reg[31:0];
            4'd4:    in_word = key1_reg[63:32];
            4'd5:    in_word = short_reg ? TAU1 : SIGMA1;
            4'd6:    in_word = nonce_reg[31:0];
            4'd7:    in_word = nonce_reg[63:32];
            4'd8:    in_word = counter_reg[31:0];
            4'd9:    in_word = counter_reg[63:32];
            4'd10:   in_word = short_reg ? TAU2 : SIGMA2;
            4'd11:   in_word = short_reg ? key0_reg[31:0]  : key2_reg[31:0];
            4'd12:   in_word = short_reg ? key0_reg[63:32] : key2_reg[63:32];
            4'd13:   in_word = short_reg ? key1_reg[31:0]  : key3_reg[31:0];
            4'd14:   in_word = short_reg ? key1_reg[63:32] : key3_reg[63:32];
            4'd15:   in_word = SIGMA3;
            default: in_word = SIGMA0;
        endcase
    end

    // working word picked by the step counter for write-back
    always_comb
    begin
        unique case (ctl.step)
            2'd0:    w_sel = w0_reg;
            2'd1:    w_sel = w1_reg;
            2'd2:    w_sel = w2_reg;
            2'd3:    w_sel = w3_reg;
            default: w_sel = w0_reg;
        endcase
    end

    // shared unit operands: round step or feed-forward add
    always_comb
    begin
        alu_a   = ram_rdata;
        alu_b   = in_word;
        alu_rot = ROT_0;
        if (ctl.state == ST_QCALC)
        begin
            alu_rot = rot_of(ctl.step);
            unique case (ctl.step)
                2'd0:
                begin
                    alu_a = w0_reg;
                    alu_b = w3_reg;
                end
                2'd1:
                begin
                    alu_a = w1_reg;
                    alu_b = w0_reg;
                end
                2'd2:
                begin
                    alu_a = w2_reg;
                    alu_b = w1_reg;
                end
                2'd3:
                begin
                    alu_a = w3_reg;
                    alu_b = w2_reg;
                end
                default:
                begin
                    alu_a = w0_reg;
                    alu_b = w3_reg;
                end
            endcase
        end
    end

    salsa_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .rot (alu_rot),
        .y   (alu_y)
    );

    // state ram port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ctl.widx;
        ram_wdata = in_word;
        ram_re    = 1'b0;
        ram_raddr = pos_reg[5:2];
        unique case (ctl.state)
            ST_IDLE:   ram_re = 1'b1;
            ST_KS_RD:  ram_re = 1'b1;
            ST_INIT:   ram_we = 1'b1;
            ST_QLOAD:
            begin
                ram_re    = 1'b1;
                ram_raddr = qr_addr(ctl.quarter, ctl.step);
            end
            ST_QSTORE:
            begin
                ram_we    = 1'b1;
                ram_waddr = qr_addr(ctl.quarter, ctl.step);
                ram_wdata = w_sel;
            end
            ST_FF_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = ctl.widx;
            end
            ST_FF_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = alu_y;
            end
            default:   ram_re = 1'b0;
        endcase
    end

    salsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // capture of loaded quarter words in the cycle after the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_en_reg  <= 1'b0;
            cap_idx_reg <= '0;
        end
        else
        begin
            cap_en_reg  <= ctl.state == ST_QLOAD;
            cap_idx_reg <= ctl.step;
        end
    end

    // working words: load from ram, then four round steps
    always_ff @(posedge clk)
    begin
        if (cap_en_reg)
        begin
            unique case (cap_idx_reg)
                2'd0:    w0_reg <= ram_rdata;
                2'd1:    w1_reg <= ram_rdata;
                2'd2:    w2_reg <= ram_rdata;
                2'd3:    w3_reg <= ram_rdata;
                default: w0_reg <= ram_rdata;
            endcase
        end
        else if (ctl.state == ST_QCALC)
        begin
            unique case (ctl.step)
                2'd0:    w1_reg <= w1_reg ^ alu_y;
                2'd1:    w2_reg <= w2_reg ^ alu_y;
                2'd2:    w3_reg <= w3_reg ^ alu_y;
                2'd3:    w0_reg <= w0_reg ^ alu_y;
                default: w1_reg <= w1_reg ^ alu_y;
            endcase
        end
    end

    // block counter and byte position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            pos_reg     <= BLOCK_BYTES;
        end
        else if (cfg_hit)
        begin
            counter_reg <= '0;
            pos_reg     <= BLOCK_BYTES;
        end
        else if (block_done)
        begin
            counter_reg <= counter_reg + 64'd1;
            pos_reg     <= '0;
        end
        else if (deliver)
        begin
            pos_reg <= pos_reg + 7'd1;
        end
    end

    // input byte held while the keystream byte is fetched
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            data_reg <= s_tdata;
        end
    end

    assign ks_byte = ram_rdata[{pos_reg[1:0], 3'b000} +: 8];

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (deliver)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (deliver)
        begin
            m_data_reg <= data_reg ^ ks_byte;
        end
    end

    // byte position never runs past the end of the block
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= BLOCK_BYTES)
        else $error("byte position beyond block end");

    // a keystream byte is only delivered from a computed block
    assert property (@(posedge clk) disable iff (!rst_n) deliver |-> pos_reg < BLOCK_BYTES)
        else $error("keystream byte taken from an exhausted block");

    // one transaction at a time: accepting an item drops ready
    assert property (@(posedge clk) disable iff (!rst_n) start |=> !s_tready)
        else $error("input accepted while busy");

    // finishing a block leaves the position at its first byte
    assert property (@(posedge clk) disable iff (!rst_n)
                     (block_done && !cfg_hit) |=> pos_reg == '0)
        else $error("block finished without position restart");

endmodule

// ----- sim/tb_salsa20_stream_cipher_core.sv -----
// testbench for salsa20_stream_cipher_core: byte stream checked against a built-in salsa20 predictor
`timescale 1ns / 100ps

module tb_salsa20_stream_cipher_core import salsa_pkg::*; ();

    localparam logic [2:0] CFG_UNUSED     = 3'd7;
    localparam int         TOTAL_BYTES    = 1850;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 20000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // data_in[7:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;             // data_out[7:0]
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = 3'd0;
    logic [63:0] cfg_wdata = 64'd0;

    // predictor copy of configuration and keystream state
    logic [63:0] key_w [4];
    logic        short_mode;
    logic [63:0] nonce_w;
    logic [4:0]  rounds_w;
    logic [7:0]  ks_bytes [64];
    int          ks_pos;
    logic [63:0] blk_ctr;
    logic [31:0] mix_w  [16];
    logic [31:0] init_w [16];

    // expected cipher bytes, oldest first
    logic [7:0]  cipher_expected [$];

    int          fail_cnt     = 0;
    int          bytes_sent   = 0;
    int          src_gap_max  = 8;
    int          sink_gap_max = 8;
    bit          sink_hold_req = 1'b0;
    int          idle_cycles  = 0;

    salsa20_stream_cipher_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // quarter round on the working words
    function automatic void qround(input int a, input int b, input int c, input int d);
        mix_w[b] = mix_w[b] ^ rol32(mix_w[a] + mix_w[d], 7);
        mix_w[c] = mix_w[c] ^ rol32(mix_w[b] + mix_w[a], 9);
        mix_w[d] = mix_w[d] ^ rol32(mix_w[c] + mix_w[b], 13);
        mix_w[a] = mix_w[a] ^ rol32(mix_w[d] + mix_w[c], 18);
    endfunction

    // build the next 64 keystream bytes from key, nonce and block counter
    function automatic void refill_keystream();
        logic [31:0] k [8];
        logic [31:0] cw1;
        logic [31:0] cw2;
        logic [31:0] sum;
        int          dbl;
        k[0] = key_w[0][31:0];
        k[1] = key_w[0][63:32];
        k[2] = key_w[1][31:0];
        k[3] = key_w[1][63:32];
        if (short_mode)
        begin
            for (int i = 0; i < 4; i++) k[i + 4] = k[i];
            cw1 = TAU1;
            cw2 = TAU2;
        end
        else
        begin
            k[4] = key_w[2][31:0];
            k[5] = key_w[2][63:32];
            k[6] = key_w[3][31:0];
            k[7] = key_w[3][63:32];
            cw1  = SIGMA1;
            cw2  = SIGMA2;
        end
        init_w[0]  = SIGMA0;
        for (int i = 0; i < 4; i++) init_w[i + 1] = k[i];
        init_w[5]  = cw1;
        init_w[6]  = nonce_w[31:0];
        init_w[7]  = nonce_w[63:32];
        init_w[8]  = blk_ctr[31:0];
        init_w[9]  = blk_ctr[63:32];
        init_w[10] = cw2;
        for (int i = 0; i < 4; i++) init_w[i + 11] = k[i + 4];
        init_w[15] = SIGMA3;
        for (int i = 0; i < 16; i++) mix_w[i] = init_w[i];
        // odd counts round up to the next even count
        dbl = (int'(rounds_w) + 1) / 2;
        for (int r = 0; r < dbl; r++)
        begin
            qround(0, 4, 8, 12);
            qround(5, 9, 13, 1);
            qround(10, 14, 2, 6);
            qround(15, 3, 7, 11);
            qround(0, 1, 2, 3);
            qround(5, 6, 7, 4);
            qround(10, 11, 8, 9);
            qround(15, 12, 13, 14);
        end
        // feed-forward and little-endian byte split
        for (int i = 0; i < 16; i++)
        begin
            sum = mix_w[i] + init_w[i];
            for (int j = 0; j < 4; j++) ks_bytes[4 * i + j] = sum[8 * j +: 8];
        end
    endfunction

    // expected output for one accepted input byte
    function automatic logic [7:0] next_cipher_byte(input logic [7:0] b);
        if (ks_pos >= 64)
        begin
            refill_keystream();
            blk_ctr = blk_ctr + 64'd1;
            ks_pos  = 0;
        end
        ks_pos = ks_pos + 1;
        return b ^ ks_bytes[ks_pos - 1];
    endfunction

    function automatic logic [63:0] pick_word64();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 64'd0;
        else if (sel == 1)
            return '1;
        else
            return {$urandom, $urandom};
    endfunction

    // one input transaction with a random lead-in gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        cipher_expected.insert(cipher_expected.size(), next_cipher_byte(b));
        bytes_sent = bytes_sent + 1;
    endtask

    // stop offering input and wait until every result is back
    task automatic drain_stream();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (cipher_expected.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // register write, mirrored into the predictor
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        bit known;
        known = 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_KEY0:   key_w[0]   = val;
            CFG_KEY1:   key_w[1]   = val;
            CFG_KEY2:   key_w[2]   = val;
            CFG_KEY3:   key_w[3]   = val;
            CFG_SHORT:  short_mode = val[0];
            CFG_NONCE:  nonce_w    = val;
            CFG_ROUNDS: rounds_w   = val[4:0];
            default:    known      = 1'b0;
        endcase
        // a defined index restarts the stream
        if (known)
        begin
            blk_ctr = 64'd0;
            ks_pos  = 64;
        end
    endtask

    // reset configuration: zero key and nonce, 20 rounds
    task automatic test_reset_defaults();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h01);
        send_byte(8'h80);
    endtask

    // all-ones key and nonce, long key mode
    task automatic test_key_extremes();
        drain_stream();
        cfg_write(CFG_KEY0, '1);
        cfg_write(CFG_KEY1, '1);
        cfg_write(CFG_KEY2, '1);
        cfg_write(CFG_KEY3, '1);
        cfg_write(CFG_SHORT, 64'd0);
        cfg_write(CFG_NONCE, '1);
        cfg_write(CFG_ROUNDS, 64'd20);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h7f);
    endtask

    // short key: upper key half is ignored, tau constants in use
    task automatic test_short_key();
        drain_stream();
        cfg_write(CFG_KEY0, 64'h0123456789abcdef);
        cfg_write(CFG_KEY1, 64'hfedcba9876543210);
        cfg_write(CFG_KEY2, 64'h5555aaaa5555aaaa);
        cfg_write(CFG_KEY3, 64'haaaa5555aaaa5555);
        cfg_write(CFG_SHORT, 64'd1);
        send_byte(8'h55);
        send_byte(8'haa);
        send_byte(8'hfe);
    endtask

    // zero rounds, odd counts, and the largest count the field holds
    task automatic test_round_counts();
        drain_stream();
        cfg_write(CFG_ROUNDS, 64'd0);
        send_byte(8'h3c);
        send_byte(8'hc3);
        drain_stream();
        cfg_write(CFG_ROUNDS, 64'd1);
        send_byte(8'h0f);
        send_byte(8'hf0);
        drain_stream();
        cfg_write(CFG_ROUNDS, 64'd31);
        send_byte(8'h81);
        send_byte(8'h18);
        drain_stream();
        cfg_write(CFG_ROUNDS, 64'd2);
        send_byte(8'h42);
        send_byte(8'hbd);
    endtask

    // a write to an index past the register list leaves the stream running
    task automatic test_unused_index();
        drain_stream();
        cfg_write(CFG_UNUSED, '1);
        send_byte(8'h11);
        send_byte(8'hee);
        send_byte(8'h99);
    endtask

    // receiver stalls for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        drain_stream();
        cfg_write(CFG_ROUNDS, 64'd8);
        src_gap_max   = 0;
        sink_hold_req = 1'b1;
        repeat (40) send_byte(8'($urandom));
        src_gap_max   = 8;
    endtask

    // phases of random configuration and random byte runs
    task automatic test_random_stream();
        int          len;
        bit          first;
        logic [63:0] wd;
        first = 1'b1;
        while (bytes_sent < TOTAL_BYTES)
        begin
            drain_stream();
            if (first || $urandom_range(0, 1) == 0) cfg_write(CFG_KEY0, pick_word64());
            if (first || $urandom_range(0, 1) == 0) cfg_write(CFG_KEY1, pick_word64());
            if (first || $urandom_range(0, 1) == 0) cfg_write(CFG_KEY2, pick_word64());
            if (first || $urandom_range(0, 1) == 0) cfg_write(CFG_KEY3, pick_word64());
            if (first || $urandom_range(0, 1) == 0) cfg_write(CFG_NONCE, pick_word64());
            if (first || $urandom_range(0, 1) == 0)
            begin
                wd    = {$urandom, $urandom};
                wd[0] = 1'($urandom);
                cfg_write(CFG_SHORT, wd);
            end
            if (first || $urandom_range(0, 1) == 0)
            begin
                wd      = {$urandom, $urandom};
                wd[4:0] = ($urandom_range(0, 3) == 0) ? 5'd20 : 5'($urandom_range(0, 31));
                cfg_write(CFG_ROUNDS, wd);
            end
            if ($urandom_range(0, 7) == 0) cfg_write(CFG_UNUSED, {$urandom, $urandom});
            first = 1'b0;
            src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 8;
            sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(130, 300)
                                               : $urandom_range(1, 130);
            // last run stops at the byte total
            if (len > TOTAL_BYTES - bytes_sent) len = TOTAL_BYTES - bytes_sent;
            repeat (len) send_byte(8'($urandom));
        end
        src_gap_max  = 8;
        sink_gap_max = 8;
    endtask

    // receiver: random ready gaps, one long hold-off on request
    initial
    begin : result_sink
        int gap;
        while (!rst_n) @(negedge clk);
        forever
        begin
            gap = $urandom_range(0, sink_gap_max);
            if (sink_hold_req)
            begin
                gap           = HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // compare each output transaction with the oldest expected byte
    always @(posedge clk)
    begin : result_check
        logic [7:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cipher_expected.size() == 0)
            begin
                $error("data_out: unexpected result, actual %02h", m_tdata);
                fail_cnt = fail_cnt + 1;
            end
            else
            begin
                want = cipher_expected.pop_front();
                if (m_tdata !== want)
                begin
                    $error("data_out mismatch: expected %02h actual %02h", want, m_tdata);
                    fail_cnt = fail_cnt + 1;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_salsa20_stream_cipher_core failed");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin : stimulus
        for (int i = 0; i < 4; i++) key_w[i] = 64'd0;
        for (int i = 0; i < 64; i++) ks_bytes[i] = 8'h00;
        short_mode = 1'b0;
        nonce_w    = 64'd0;
        rounds_w   = ROUNDS_RESET;
        ks_pos     = 64;
        blk_ctr    = 64'd0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_key_extremes();
        test_short_key();
        test_round_counts();
        test_unused_index();
        test_backpressure();
        test_random_stream();
        drain_stream();
        repeat (8) @(posedge clk);
        if (fail_cnt == 0)
            $display("tb_salsa20_stream_cipher_core passed");
        else
            $display("tb_salsa20_stream_cipher_core failed");
        $finish;
    end

endmodule

// ----- salsa20_stream_cipher_core.f -----
rtl/salsa_pkg.sv
rtl/salsa_ram.sv
rtl/salsa_alu.sv
rtl/salsa_ctrl.sv
rtl/salsa20_stream_cipher_core.sv
sim/tb_salsa20_stream_cipher_core.sv
